>>> hw/rtl/lpc_pkg.sv
// lpc_pkg: shared constants, types and state codes for the lru page cache
// no dependencies; imported by lpc_cell, lpc_ctrl and lru_page_cache
package lpc_pkg;

   // default geometry
   localparam int CAPACITY_DEF = 1024;
   localparam int KEY_BITS_DEF = 32;

   // fixed field widths
   localparam int PAGE_BITS  = 32;
   localparam int COUNT_BITS = 32;
   localparam int SLOT_BITS  = 11;

   localparam logic [SLOT_BITS-1:0]  SLOTS_RESET = SLOT_BITS'(1024);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX   = '1;

   // token that runs back towards the head once the walk has stopped
   typedef struct packed {
      logic valid;
      logic hit;
   } back_type;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } ctrl_state_type;

endpackage

>>> hw/rtl/lpc_cell.sv
// lpc_cell: one recency slot of the chain, holds one key
// depends on lpc_pkg (back_type)
module lpc_cell #(
   parameter int IDX      = 0,
   parameter int KEY_BITS = 32,
   parameter int OW       = 11,
   parameter bit IS_TAIL  = 1'b0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wave_in_valid,
   input  logic [KEY_BITS-1:0] wave_in_key,
   input  logic [KEY_BITS-1:0] access_key,
   input  logic [OW-1:0]       occ,
   input  lpc_pkg::back_type   back_in,
   output logic                wave_out_valid,
   output logic [KEY_BITS-1:0] wave_out_key,
   output lpc_pkg::back_type   back_out
);
   import lpc_pkg::*;

   localparam logic [OW-1:0] MY_POS = OW'(IDX);

   logic [KEY_BITS-1:0] key_ff;
   logic                fwd_valid_ff, fwd_valid_in;
   logic [KEY_BITS-1:0] fwd_key_ff;
   back_type            back_ff, back_in_nxt;
   logic                live, match, stop;

   // slot holds a key when it lies below the occupancy
   assign live  = MY_POS < occ;
   assign match = live && (key_ff == access_key);
   assign stop  = !live || match || IS_TAIL;

   // walk goes on past this slot only while nothing stops it here
   assign fwd_valid_in = wave_in_valid && !stop;

   // stop report, or pass on what comes from further down
   always_comb begin
      if (wave_in_valid && stop) begin
         back_in_nxt.valid = 1'b1;
         back_in_nxt.hit   = match;
      end else begin
         back_in_nxt = back_in;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
         back_ff      <= '0;
      end else begin
         fwd_valid_ff <= fwd_valid_in;
         back_ff      <= back_in_nxt;
      end
   end

   // key shifts in from the neighbour, old key moves on
   always_ff @(posedge clock) begin
      if (wave_in_valid) begin
         key_ff     <= wave_in_key;
         fwd_key_ff <= key_ff;
      end
   end

   assign wave_out_valid = fwd_valid_ff;
   assign wave_out_key   = fwd_key_ff;
   assign back_out       = back_ff;

endmodule

>>> hw/rtl/lpc_ctrl.sv
// lpc_ctrl: command handshake, slot limit register, occupancy and counters
// depends on lpc_pkg (state codes, back_type, widths)
module lpc_ctrl #(
   parameter int CAPACITY = 1024,
   parameter int KEY_BITS = 32,
   parameter int OW       = 11
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [lpc_pkg::PAGE_BITS-1:0]       req_page,
   input  logic                                csr_wr_en,
   input  logic [lpc_pkg::SLOT_BITS-1:0]       csr_wr_data,
   output logic                                rsp_valid,
   output logic                                rsp_hit,
   output logic [lpc_pkg::COUNT_BITS-1:0]      rsp_hits_so_far,
   output logic [lpc_pkg::COUNT_BITS-1:0]      rsp_accesses_so_far,
   output logic                                go,
   output logic [KEY_BITS-1:0]                 access_key,
   output logic [OW-1:0]                       occ,
   input  lpc_pkg::back_type                   head_back
);
   import lpc_pkg::*;

   localparam int CB = (KEY_BITS < PAGE_BITS) ? KEY_BITS : PAGE_BITS;

   ctrl_state_type       state_ff, state_in;
   logic [SLOT_BITS-1:0] slots_ff;
   logic [KEY_BITS-1:0]  key_ff;
   logic                 go_ff, go_in;
   logic [OW-1:0]        occ_ff, occ_in;
   logic [COUNT_BITS-1:0] hits_ff, hits_in, acc_ff, acc_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_hit_ff;
   logic [OW-1:0]        lim;
   logic                 accept, done;

   assign accept = start && (state_ff == ST_IDLE);
   assign done   = (state_ff == ST_WALK) && head_back.valid;

   // effective limit: zero reads as one, clamp at capacity
   always_comb begin
      if (slots_ff == '0) begin
         lim = OW'(1);
      end else if (32'(slots_ff) > CAPACITY) begin
         lim = OW'(CAPACITY);
      end else begin
         lim = OW'(slots_ff);
      end
   end

   // next state, walk launch and bookkeeping on completion
   always_comb begin
      state_in     = state_ff;
      go_in        = 1'b0;
      occ_in       = occ_ff;
      hits_in      = hits_ff;
      acc_in       = acc_ff;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               go_in    = 1'b1;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (done) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (acc_ff != COUNT_MAX) begin
                  acc_in = acc_ff + 1'b1;
               end
               if (head_back.hit) begin
                  if (hits_ff != COUNT_MAX) begin
                     hits_in = hits_ff + 1'b1;
                  end
               end else if (occ_ff >= lim) begin
                  occ_in = lim;
               end else begin
                  occ_in = occ_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         go_ff        <= 1'b0;
         occ_ff       <= '0;
         hits_ff      <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         slots_ff     <= SLOTS_RESET;
      end else begin
         state_ff     <= state_in;
         go_ff        <= go_in;
         occ_ff       <= occ_in;
         hits_ff      <= hits_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            slots_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff <= KEY_BITS'(req_page[CB-1:0]);
      end
      if (done) begin
         rsp_hit_ff <= head_back.hit;
      end
   end

   assign busy                = (state_ff != ST_IDLE);
   assign go                  = go_ff;
   assign access_key          = key_ff;
   assign occ                 = occ_ff;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_hit             = rsp_hit_ff;
   assign rsp_hits_so_far     = hits_ff;
   assign rsp_accesses_so_far = acc_ff;

endmodule

>>> hw/rtl/lru_page_cache.sv
// lru_page_cache: fully associative page cache with lru replacement, top level
// depends on lpc_pkg, lpc_cell and lpc_ctrl
//
// One page key is taken per command (start while busy is low) and exactly one
// result beat follows, shown for a single cycle on rsp_valid; the receiver
// cannot stall it. Keys sit in a chain of CAPACITY cells, newest at the head.
// An access launches a walk down the chain, one cell per cycle, that shifts
// keys back by one until it meets the matching key, the first empty cell or
// the tail; a stop token then runs back to the head, one cell per cycle. Busy
// stays high while the walk and the stop token are under way and drops as the
// result beat is shown. No clearing pass is needed after reset. The slot
// limit (csr_wr_data, zero read as one, clamped to CAPACITY) may be written
// only while busy is low.
module lru_page_cache #(
   parameter int CAPACITY = lpc_pkg::CAPACITY_DEF,
   parameter int KEY_BITS = lpc_pkg::KEY_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [lpc_pkg::PAGE_BITS-1:0]  req_page,
   input  logic                           csr_wr_en,
   input  logic [lpc_pkg::SLOT_BITS-1:0]  csr_wr_data,
   output logic                           rsp_valid,
   output logic                           rsp_hit,
   output logic [lpc_pkg::COUNT_BITS-1:0] rsp_hits_so_far,
   output logic [lpc_pkg::COUNT_BITS-1:0] rsp_accesses_so_far
);
   import lpc_pkg::*;

   localparam int OW = $clog2(CAPACITY + 1);

   logic                go;
   logic [KEY_BITS-1:0] access_key;
   logic [OW-1:0]       occ;
   logic                wave_v [CAPACITY];
   logic [KEY_BITS-1:0] wave_k [CAPACITY];
   back_type            back_bus [CAPACITY];

   // command, limit, occupancy and counters
   lpc_ctrl #(
      .CAPACITY (CAPACITY),
      .KEY_BITS (KEY_BITS),
      .OW       (OW)
   ) u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_page            (req_page),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .rsp_valid           (rsp_valid),
      .rsp_hit             (rsp_hit),
      .rsp_hits_so_far     (rsp_hits_so_far),
      .rsp_accesses_so_far (rsp_accesses_so_far),
      .go                  (go),
      .access_key          (access_key),
      .occ                 (occ),
      .head_back           (back_bus[0])
   );

   // chain of recency cells, head at index zero
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                in_v;
      logic [KEY_BITS-1:0] in_k;
      back_type            in_b;

      if (i == 0) begin : g_head
         assign in_v = go;
         assign in_k = access_key;
      end else begin : g_body
         assign in_v = wave_v[i-1];
         assign in_k = wave_k[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign in_b = '0;
      end else begin : g_link
         assign in_b = back_bus[i+1];
      end

      lpc_cell #(
         .IDX      (i),
         .KEY_BITS (KEY_BITS),
         .OW       (OW),
         .IS_TAIL  (i == CAPACITY - 1)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .wave_in_valid  (in_v),
         .wave_in_key    (in_k),
         .access_key     (access_key),
         .occ            (occ),
         .back_in        (in_b),
         .wave_out_valid (wave_v[i]),
         .wave_out_key   (wave_k[i]),
         .back_out       (back_bus[i])
      );
   end

endmodule
